/* hw/rtl/two_level_directory_table_top_macros.svh */
// ----------------------------------------------------------------------------
// two_level_directory_table_top_macros
// assertion macros shared by the checker, clocked on clk_i, reset rst_ni
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_DIRECTORY_TABLE_TOP_MACROS_SVH
`define TWO_LEVEL_DIRECTORY_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define TLDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tldt_pkg.sv */
// ----------------------------------------------------------------------------
// tldt_pkg
// types and constants of the two-level directory table
// ----------------------------------------------------------------------------
package tldt_pkg;

  localparam int unsigned NUM_DIRS      = 16;
  localparam int unsigned SLOTS_PER_DIR = 16;
  localparam int unsigned NAME_CHARS    = 7;

  localparam int unsigned DIR_W     = $clog2(NUM_DIRS);
  localparam int unsigned SLOT_W    = $clog2(SLOTS_PER_DIR);
  localparam int unsigned CNT_W     = $clog2(SLOTS_PER_DIR + 1);
  localparam int unsigned ADDR_W    = DIR_W + SLOT_W;
  localparam int unsigned RAM_DEPTH = NUM_DIRS * SLOTS_PER_DIR;

  localparam int unsigned NAME_W  = 56;
  localparam int unsigned KEY_W   = 8 * NAME_CHARS;
  localparam logic [NAME_W-1:0] KEY_MASK = NAME_W'({64{1'b1}} >> (64 - KEY_W));

  localparam logic [4:0] MAX_FILES_RST = 5'd10;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_DUP      = 3'd1,
    STS_FULL     = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  dir_select;
    logic [55:0] name_key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] position;
    logic [4:0] file_count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NAME_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* hw/rtl/tldt_name_ram.sv */
// ----------------------------------------------------------------------------
// tldt_name_ram
// name slot memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tldt_name_ram (
  input  logic                            clk_i,
  input  tldt_pkg::ram_req_t              ram_req_i,
  output logic [tldt_pkg::NAME_W-1:0]     rdata_o
);
  import tldt_pkg::*;

  logic [NAME_W-1:0] mem_q [RAM_DEPTH];
  logic [NAME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem_q[ram_req_i.waddr] <= ram_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_req_i.re) begin
      rdata_q <= mem_q[ram_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tldt_ctrl.sv */
// ----------------------------------------------------------------------------
// tldt_ctrl
// request sequencer: one slot compare or one slot move per cycle
// ----------------------------------------------------------------------------
module tldt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [4:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  tldt_pkg::req_t                in_data_i,
  output logic                          in_ready_o,
  input  logic                          rsp_free_i,
  output logic                          rsp_valid_o,
  output tldt_pkg::rsp_t                rsp_o,
  output tldt_pkg::ram_req_t            ram_req_o,
  input  logic [tldt_pkg::NAME_W-1:0]   ram_rdata_i
);
  import tldt_pkg::*;

  state_e               state_q, state_d;
  logic [1:0]           req_q, req_d;
  logic [DIR_W-1:0]     dir_q, dir_d;
  logic [NAME_W-1:0]    key_q, key_d;
  logic [CNT_W-1:0]     rd_slot_q, rd_slot_d;
  logic                 pend_q, pend_d;
  logic [SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  status_e              status_q, status_d;
  logic [SLOT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]     counts_q [NUM_DIRS];
  logic [CNT_W-1:0]     counts_d [NUM_DIRS];
  logic [4:0]           max_files_q;

  logic                 accept;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CNT_W-1:0]     cap;
  logic                 key_hit;
  logic                 more;
  logic                 skip;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign cnt_cur = counts_q[dir_q];
  assign cap     = (CNT_W'(max_files_q) < CNT_W'(SLOTS_PER_DIR)) ?
                   CNT_W'(max_files_q) : CNT_W'(SLOTS_PER_DIR);
  // ram data holds the slot read last cycle
  assign key_hit = pend_q && (ram_rdata_i == key_q);
  assign more    = (rd_slot_q < cnt_cur);

  always_comb begin
    case (req_q)
      REQ_CREATE: skip = (cnt_cur >= cap);
      REQ_DELETE: skip = (cnt_cur == '0);
      REQ_SEARCH: skip = 1'b0;
      default:    skip = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = skip ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (key_hit) begin
          state_d = (req_q == REQ_DELETE) ? S_SHIFT : S_DONE;
        end else if (!more) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!more) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    dir_d       = dir_q;
    key_d       = key_q;
    rd_slot_d   = rd_slot_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    status_d    = status_q;
    pos_d       = pos_q;
    counts_d    = counts_q;
    ram_req_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = in_data_i.req_type;
          dir_d = in_data_i.dir_select[DIR_W-1:0];
          key_d = in_data_i.name_key & KEY_MASK;
        end
      end
      S_CHECK: begin
        status_d  = STS_OK;
        pos_d     = '0;
        rd_slot_d = '0;
        pend_d    = 1'b0;
        if (req_q == REQ_CREATE && skip) begin
          status_d = STS_FULL;
        end else if (req_q == REQ_DELETE && skip) begin
          status_d = STS_EMPTY;
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          pos_d  = pend_slot_q;
          pend_d = 1'b0;
          if (req_q == REQ_CREATE) begin
            status_d = STS_DUP;
          end
          // delete: move the later slots down starting one past the hit
          rd_slot_d = CNT_W'(pend_slot_q) + CNT_W'(1);
        end else if (more) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = {dir_q, rd_slot_q[SLOT_W-1:0]};
          rd_slot_d       = rd_slot_q + CNT_W'(1);
          pend_d          = 1'b1;
          pend_slot_d     = rd_slot_q[SLOT_W-1:0];
        end else begin
          pend_d = 1'b0;
          if (req_q == REQ_CREATE) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = {dir_q, cnt_cur[SLOT_W-1:0]};
            ram_req_o.wdata = key_q;
            pos_d           = cnt_cur[SLOT_W-1:0];
            counts_d[dir_q] = cnt_cur + CNT_W'(1);
          end else begin
            status_d = STS_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = {dir_q, pend_slot_q};
          ram_req_o.wdata = ram_rdata_i;
        end
        if (more) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = {dir_q, rd_slot_q[SLOT_W-1:0]};
          rd_slot_d       = rd_slot_q + CNT_W'(1);
          pend_d          = 1'b1;
          pend_slot_d     = SLOT_W'(rd_slot_q - CNT_W'(1));
        end else begin
          pend_d          = 1'b0;
          counts_d[dir_q] = cnt_cur - CNT_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid_o         = (state_q == S_DONE);
  assign rsp_o.status        = status_q;
  assign rsp_o.position      = 4'(pos_q);
  assign rsp_o.file_count    = 5'(cnt_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      max_files_q <= MAX_FILES_RST;
      for (int i = 0; i < NUM_DIRS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      counts_q <= counts_d;
      if (cfg_we_i) begin
        max_files_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    dir_q       <= dir_d;
    key_q       <= key_d;
    rd_slot_q   <= rd_slot_d;
    pend_slot_q <= pend_slot_d;
    status_q    <= status_d;
    pos_q       <= pos_d;
  end

endmodule

/* hw/rtl/two_level_directory_table_top.sv */
// ----------------------------------------------------------------------------
// two_level_directory_table_top
// sequence: create, search and delete scan the files of the selected directory;
//   a delete that hits then moves the later slots down; full, empty and
//   unused codes skip the scan
// throughput: one request at a time, the next is taken once the response is
//   registered; one name-ram slot per cycle sets the pace
// reset: counts cleared, max_files 10; name slots undefined until written
// ----------------------------------------------------------------------------
module two_level_directory_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tldt_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tldt_pkg::rsp_t   out_data_o
);
  import tldt_pkg::*;

  ram_req_t          ram_req;
  logic [NAME_W-1:0] ram_rdata;
  logic              rsp_valid;
  rsp_t              rsp;
  logic              rsp_free;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q;

  tldt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .rsp_free_i  (rsp_free),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  tldt_name_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (ram_rdata)
  );

  // output beat register, refilled as soon as the old beat leaves
  assign rsp_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_free) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/tldt_checker.sv */
// ----------------------------------------------------------------------------
// tldt_checker
// port-level checks of the directory table, bound to the top level
// ----------------------------------------------------------------------------
`include "two_level_directory_table_top_macros.svh"

module tldt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input tldt_pkg::rsp_t   out_data_o
);
  import tldt_pkg::*;

  logic cnt_ok;
  logic reject_sts;
  logic empty_sts;

  assign cnt_ok     = (out_data_o.file_count <= 5'(SLOTS_PER_DIR));
  assign reject_sts = (out_data_o.status == STS_FULL) || (out_data_o.status == STS_EMPTY) ||
                      (out_data_o.status == STS_NOTFOUND);
  assign empty_sts  = (out_data_o.status == STS_EMPTY);

  // one request in flight at a time
  `TLDT_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  `TLDT_ASSERT_IMP(a_count_bound, out_valid_o, cnt_ok, "count above slots")

  // rejected requests report slot zero
  `TLDT_ASSERT_IMP(a_reject_pos, out_valid_o && reject_sts, out_data_o.position == 4'd0, "reject pos")

  `TLDT_ASSERT_IMP(a_empty_count, out_valid_o && empty_sts, out_data_o.file_count == 5'd0, "empty count")

  `TLDT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "hold")

endmodule

bind two_level_directory_table_top tldt_checker u_checker (.*);
